// File: hw/rtl/cmvm_pkg.sv
package cmvm_pkg;

	localparam int DEF_MAX_ROWS      = 64;
	localparam int DEF_OPERAND_WIDTH = 32;

	localparam int ENTRY_W    = 32;
	localparam int IN_DATA_W  = 64;
	localparam int ROW_IDX_W  = 6;
	localparam int SUM_W      = 64;
	localparam int OUT_DATA_W = 72;

	localparam int ROWS_W     = 7;
	localparam int COLS_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [COLS_W-1:0] COLS_RESET = 16'd1;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic             sat;
		logic [SUM_W-1:0] sum;
	} acc_word_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic clr_all;
	} rd_ctl_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_EMIT,
		ST_TAIL
	} state_t;

endpackage

// File: hw/rtl/cmvm_acc_mem.sv
module cmvm_acc_mem
	import cmvm_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int RAW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rd_ctl_t        rd_ctl,
	input  logic [RAW-1:0] rd_addr,
	output acc_word_t      rd_data,
	input  logic           wr_en,
	input  logic [RAW-1:0] wr_addr,
	input  acc_word_t      wr_data
);

	acc_word_t             mem [MAX_ROWS];
	acc_word_t             rd_word_q;
	logic                  rd_vld_q;
	logic [MAX_ROWS-1:0]   valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_ctl.en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// entries not written since reset or since their last emit read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_ctl.en && rd_ctl.clr) begin
				if (rd_ctl.clr_all) begin
					valid_q <= '0;
				end else begin
					valid_q[rd_addr] <= 1'b0;
				end
			end
			if (rd_ctl.en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

// File: hw/rtl/cmvm_mac.sv
module cmvm_mac
	import cmvm_pkg::*;
#(
	parameter int MAX_ROWS      = DEF_MAX_ROWS,
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH,
	parameter int RAW           = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_accept,
	input  logic signed [OPERAND_WIDTH-1:0] in_matrix,
	input  logic signed [OPERAND_WIDTH-1:0] in_vector,
	input  logic [RAW-1:0]                  in_row,
	input  logic                            in_end,
	output rd_ctl_t                         rd_ctl,
	output logic [RAW-1:0]                  rd_addr,
	input  acc_word_t                       rd_data,
	output logic                            wr_en,
	output logic [RAW-1:0]                  wr_addr,
	output acc_word_t                       wr_data,
	output logic                            end_done
);

	localparam int PW = 2 * OPERAND_WIDTH;

	logic                            vld_s1;
	logic signed [OPERAND_WIDTH-1:0] m_s1;
	logic signed [OPERAND_WIDTH-1:0] v_s1;
	logic [RAW-1:0]                  row_s1;
	logic                            end_s1;

	logic                            vld_s2;
	logic signed [PW-1:0]            prod_s2;
	logic [RAW-1:0]                  row_s2;
	logic                            end_s2;

	logic                            fwd_vld_q;
	logic [RAW-1:0]                  fwd_row_q;
	acc_word_t                       fwd_word_q;

	acc_word_t                       acc_in;
	logic [SUM_W:0]                  sum_x;
	logic                            ovf;
	acc_word_t                       result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			vld_s1    <= in_accept;
			vld_s2    <= vld_s1;
			fwd_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			m_s1   <= in_matrix;
			v_s1   <= in_vector;
			row_s1 <= in_row;
			end_s1 <= in_end;
		end
		if (vld_s1) begin
			prod_s2 <= m_s1 * v_s1;
			row_s2  <= row_s1;
			end_s2  <= end_s1;
		end
		if (vld_s2) begin
			fwd_row_q  <= row_s2;
			fwd_word_q <= result;
		end
	end

	assign rd_ctl  = '{en: vld_s1, clr: 1'b0, clr_all: 1'b0};
	assign rd_addr = row_s1;

	// the read of the item right behind a write to the same row misses that write
	always_comb begin
		if (fwd_vld_q && (fwd_row_q == row_s2)) begin
			acc_in = fwd_word_q;
		end else begin
			acc_in = rd_data;
		end
		sum_x = {acc_in.sum[SUM_W-1], acc_in.sum}
			+ {{(SUM_W+1-PW){prod_s2[PW-1]}}, prod_s2};
		ovf = sum_x[SUM_W] ^ sum_x[SUM_W-1];
		result.sat = acc_in.sat | ovf;
		if (ovf) begin
			result.sum = sum_x[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			result.sum = sum_x[SUM_W-1:0];
		end
	end

	assign wr_en    = vld_s2;
	assign wr_addr  = row_s2;
	assign wr_data  = result;
	assign end_done = vld_s2 && end_s2;

endmodule

// File: hw/rtl/column_major_matrix_vector_mac_unit.sv
// Column-major dense matrix times vector, signed Q16.16 operands, saturating Q32.32 row sums.
// Send matrix entries column by column, each with the vector entry of its column; one word is
// taken per clock while a product is running. The row sums sit in an accumulator memory with
// one read and one write port that is read, updated and written back over a pipeline
// (read, multiply, add), with the previous write forwarded so one row may be hit on every
// cycle. After the entry in the last row of the last column, input stalls while that word
// drains, then one result per cycle leaves on the output port (row 0 first,
// tlast on the last row, tuser set if that row saturated), as fast as the sink takes them;
// every row is cleared by the time the last one is read. Input opens again once the last
// result has been taken. Write rows_in_use and columns_in_use only while no word is in flight;
// a write in the middle of a product keeps the counters and sums, and a counter at or past the
// new end counts as being at the end. Zero acts as one, and rows above MAX_ROWS act as MAX_ROWS.
module column_major_matrix_vector_mac_unit
	import cmvm_pkg::*;
#(
	parameter int MAX_ROWS      = DEF_MAX_ROWS,
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // matrix_entry, vector_entry
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // row_index, row_sum, zero pad
	output logic                  m_axis_tuser,   // saturated
	output logic                  m_axis_tlast
);

	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] nrows;
	logic [COLS_W-1:0] ncols;

	state_t            state_q;
	state_t            state_d;

	logic [RAW-1:0]    row_q;
	logic [COLS_W-1:0] col_q;
	logic              row_end;
	logic              col_end;
	logic              run_end;
	logic              in_accept;

	rd_ctl_t           mac_rd_ctl;
	logic [RAW-1:0]    mac_rd_addr;
	rd_ctl_t           rd_ctl;
	logic [RAW-1:0]    rd_addr;
	acc_word_t         rd_data;
	logic              wr_en;
	logic [RAW-1:0]    wr_addr;
	acc_word_t         wr_data;
	logic              mac_end_done;

	logic              emit_on;
	logic              issue;
	logic              issue_last;
	logic              move;
	logic [RAW-1:0]    rd_idx_q;
	logic              em_vld_s1;
	logic [RAW-1:0]    em_idx_s1;
	logic              em_last_s1;

	logic                 out_vld_q;
	logic [ROW_IDX_W-1:0] out_idx_q;
	logic [SUM_W-1:0]     out_sum_q;
	logic                 out_sat_q;
	logic                 out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_wdata[ROWS_W-1:0];
				REG_COLS: cols_q <= cfg_wdata[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (rows_q == '0) begin
			nrows = ROWS_W'(1);
		end else if (rows_q > ROWS_W'(MAX_ROWS)) begin
			nrows = ROWS_W'(MAX_ROWS);
		end else begin
			nrows = rows_q;
		end
		ncols = (cols_q == '0) ? COLS_W'(1) : cols_q;
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign row_end   = ({{(ROWS_W-RAW){1'b0}}, row_q} + ROWS_W'(1)) >= nrows;
	assign col_end   = ({1'b0, col_q} + (COLS_W+1)'(1)) >= {1'b0, ncols};
	assign run_end   = row_end && col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_accept) begin
			if (row_end) begin
				row_q <= '0;
				col_q <= col_end ? '0 : col_q + COLS_W'(1);
			end else begin
				row_q <= row_q + RAW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_accept && run_end) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (mac_end_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (issue && issue_last) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				if (m_axis_tvalid && m_axis_tready && m_axis_tlast) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		emit_on       = 1'b0;
		unique case (state_q)
			ST_RUN:   s_axis_tready = 1'b1;
			ST_EMIT:  emit_on = 1'b1;
			ST_FLUSH: ;
			ST_TAIL:  ;
			default: ;
		endcase
	end

	cmvm_mac #(
		.MAX_ROWS      (MAX_ROWS),
		.OPERAND_WIDTH (OPERAND_WIDTH),
		.RAW           (RAW)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_matrix (s_axis_tdata[0 +: OPERAND_WIDTH]),
		.in_vector (s_axis_tdata[ENTRY_W +: OPERAND_WIDTH]),
		.in_row    (row_q),
		.in_end    (run_end),
		.rd_ctl    (mac_rd_ctl),
		.rd_addr   (mac_rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.end_done  (mac_end_done)
	);

	// emit reads clear the row as they go, the last one clears every row
	assign move       = em_vld_s1 && (!out_vld_q || m_axis_tready);
	assign issue      = emit_on && (!em_vld_s1 || move);
	assign issue_last = ({{(ROWS_W-RAW){1'b0}}, rd_idx_q} + ROWS_W'(1)) == nrows;
	assign rd_ctl     = issue ? '{en: 1'b1, clr: 1'b1, clr_all: issue_last} : mac_rd_ctl;
	assign rd_addr    = issue ? rd_idx_q : mac_rd_addr;

	cmvm_acc_mem #(
		.MAX_ROWS (MAX_ROWS),
		.RAW      (RAW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_ctl  (rd_ctl),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			em_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (issue) begin
				rd_idx_q  <= issue_last ? '0 : rd_idx_q + RAW'(1);
				em_vld_s1 <= 1'b1;
			end else if (move) begin
				em_vld_s1 <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			em_idx_s1  <= rd_idx_q;
			em_last_s1 <= issue_last;
		end
		if (move) begin
			out_idx_q  <= ROW_IDX_W'(em_idx_s1);
			out_sum_q  <= rd_data.sum;
			out_sat_q  <= rd_data.sat;
			out_last_q <= em_last_s1;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-SUM_W-ROW_IDX_W){1'b0}}, out_sum_q, out_idx_q};
	assign m_axis_tuser  = out_sat_q;
	assign m_axis_tlast  = out_last_q;

	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && em_vld_s1))
		else $error("input open while an emit read is pending");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(issue && (wr_en || mac_rd_ctl.en)))
		else $error("emit read collides with accumulator traffic");

	a_stall_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && run_end) |=> !s_axis_tready)
		else $error("input not stalled after the final word of a run");

	a_last_row_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast)
			|-> (({1'b0, m_axis_tdata[ROW_IDX_W-1:0]} + ROWS_W'(1)) == nrows))
		else $error("tlast on a row other than the last one");

endmodule
